FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the reorder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks prop on every rising clk_i edge while rst_ni is high.
`define ITP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("itp assertion failed");
// Checks that cond is never true on a rising clk_i edge.
`define ITP_NEVER(lbl, cond) \
  `ITP_ASSERT(lbl, !(cond))
`else
`define ITP_ASSERT(lbl, prop)
`define ITP_NEVER(lbl, cond)
`endif
`endif

FILE: hw/rtl/itp_pkg.sv
// Types and constants of the infix to postfix reorder block.
package itp_pkg;

  localparam int unsigned STACK_DEPTH    = 32;
  localparam int unsigned TOKEN_ID_WIDTH = 16;
  localparam int unsigned PTR_W          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W          = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] KIND_CONST  = 3'd0;
  localparam logic [2:0] KIND_NAMED  = 3'd1;
  localparam logic [2:0] KIND_FUNC   = 3'd2;
  localparam logic [2:0] KIND_OPER   = 3'd3;
  localparam logic [2:0] KIND_LPAREN = 3'd4;
  localparam logic [2:0] KIND_RPAREN = 3'd5;

  typedef struct packed {
    logic                      req_type;
    logic [2:0]                token_kind;
    logic [TOKEN_ID_WIDTH-1:0] token_id;
    logic [2:0]                precedence;
    logic                      left_assoc;
  } in_beat_t;

  typedef struct packed {
    logic                      has_token;
    logic [TOKEN_ID_WIDTH-1:0] token_id_out;
    logic [2:0]                token_kind_out;
    logic                      last;
    logic                      overflow;
    logic                      aborted;
  } out_beat_t;

  typedef struct packed {
    logic [TOKEN_ID_WIDTH-1:0] id;
    logic [2:0]                kind;
    logic [2:0]                prec;
    logic                      assoc;
  } stack_entry_t;

  localparam int unsigned ENTRY_W = $bits(stack_entry_t);

endpackage

FILE: hw/rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/itp_out_stage.sv
// Output register stage that holds one result beat until it is taken.
module itp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  itp_pkg::out_beat_t data_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output itp_pkg::out_beat_t data_o
);
  import itp_pkg::*;

  logic      valid_q;
  out_beat_t data_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/infix_to_postfix_reorder_core.sv
// Top level of the infix to postfix token reorder block.
//
// This block turns a stream of infix tokens into postfix order with an
// operator stack held in a synchronous RAM of STACK_DEPTH entries. Each input
// beat yields one or more result beats, and the final one carries last along
// with the overflow and aborted flags. Items are handled one at a time, and
// a popped token is held back one step so that last can be set on it once
// the block knows nothing follows. The stack RAM has registered read data,
// and every stacked entry that is examined goes through a read state and
// then a decide state. Every beat ends in a final state that loads its last
// result, and an operator passes a push state before it. Output back
// pressure stalls the block only when a result must leave while the output
// register still holds an earlier beat. The stack count starts at zero after
// reset, so no clearing pass over the RAM is needed. A new input beat is
// taken while the last result of the previous one still waits in the output
// register.
module infix_to_postfix_reorder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  itp_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output itp_pkg::out_beat_t out_data_o
);
  import itp_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_PUSH,
    ST_FINAL
  } state_e;

  state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  in_beat_t     cur_q, cur_d;
  stack_entry_t pend_q, pend_d;
  logic         pend_valid_q, pend_valid_d;
  logic         ovf_q, ovf_d;
  logic         ab_q, ab_d;

  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  stack_entry_t     mem_wdata, top;
  logic [ENTRY_W-1:0] mem_rdata;

  logic       out_load, out_free;
  out_beat_t  out_beat;

  logic [CNT_W-1:0] cnt_m1;
  logic             full;
  logic             in_fire;
  logic             do_pop;

  assign cnt_m1     = count_q - CNT_W'(1);
  assign full       = (count_q == CNT_W'(STACK_DEPTH));
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign mem_raddr  = cnt_m1[PTR_W-1:0];
  assign mem_waddr  = count_q[PTR_W-1:0];
  assign top        = stack_entry_t'(mem_rdata);

  // Pop rule for the entry read from the top of the stack. An end beat pops
  // everything; a right parenthesis pops down to its left parenthesis; an
  // operator pops functions and stronger or equal left-associative operators.
  always_comb begin
    do_pop = 1'b0;
    if (cur_q.req_type) begin
      do_pop = 1'b1;
    end else if (top.kind == KIND_LPAREN) begin
      do_pop = 1'b0;
    end else if (cur_q.token_kind == KIND_OPER) begin
      do_pop = (top.kind == KIND_FUNC) || (top.prec > cur_q.precedence) ||
               ((top.prec == cur_q.precedence) && top.assoc);
    end else begin
      do_pop = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cur_d        = cur_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    ovf_d        = ovf_q;
    ab_d         = ab_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wdata    = '{id: cur_q.token_id, kind: cur_q.token_kind,
                     prec: cur_q.precedence, assoc: cur_q.left_assoc};
    out_load     = 1'b0;
    out_beat     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cur_d        = in_data_i;
          ovf_d        = 1'b0;
          ab_d         = 1'b0;
          pend_valid_d = 1'b0;
          mem_wdata    = '{id: in_data_i.token_id, kind: in_data_i.token_kind,
                           prec: in_data_i.precedence, assoc: in_data_i.left_assoc};
          if (in_data_i.req_type) begin
            state_d = (count_q != '0) ? ST_READ : ST_FINAL;
          end else begin
            unique case (in_data_i.token_kind)
              KIND_CONST, KIND_NAMED: begin
                pend_valid_d = 1'b1;
                pend_d       = mem_wdata;
                state_d      = ST_FINAL;
              end
              KIND_FUNC, KIND_LPAREN: begin
                if (full) begin
                  ovf_d = 1'b1;
                end else begin
                  mem_we  = 1'b1;
                  count_d = count_q + CNT_W'(1);
                end
                state_d = ST_FINAL;
              end
              KIND_OPER: begin
                state_d = (count_q != '0) ? ST_READ : ST_PUSH;
              end
              KIND_RPAREN: begin
                state_d = (count_q != '0) ? ST_READ : ST_FINAL;
              end
              default: begin
                count_d = '0;
                ab_d    = 1'b1;
                state_d = ST_FINAL;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (do_pop) begin
          // The held token leaves now with last clear; the popped entry
          // takes its place until the block knows whether more follow.
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_load = 1'b1;
              out_beat = '{has_token: 1'b1, token_id_out: pend_q.id,
                           token_kind_out: pend_q.kind, last: 1'b0,
                           overflow: 1'b0, aborted: 1'b0};
            end
            pend_valid_d = 1'b1;
            pend_d       = top;
            count_d      = cnt_m1;
            if (cnt_m1 == '0) begin
              state_d = (!cur_q.req_type && cur_q.token_kind == KIND_OPER) ?
                        ST_PUSH : ST_FINAL;
            end else begin
              state_d = ST_READ;
            end
          end
        end else if (cur_q.token_kind == KIND_OPER) begin
          state_d = ST_PUSH;
        end else begin
          // A right parenthesis reached its left parenthesis: drop it.
          count_d = cnt_m1;
          state_d = ST_FINAL;
        end
      end
      ST_PUSH: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        state_d = ST_FINAL;
      end
      ST_FINAL: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_beat     = '{has_token: pend_valid_q,
                           token_id_out: pend_valid_q ? pend_q.id : '0,
                           token_kind_out: pend_valid_q ? pend_q.kind : 3'd0,
                           last: 1'b1, overflow: ovf_q, aborted: ab_q};
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      ovf_q        <= 1'b0;
      ab_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      ovf_q        <= ovf_d;
      ab_q         <= ab_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
  end

  itp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  itp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (out_beat),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // The stack count never passes the RAM depth.
  `ITP_NEVER(a_count_range, count_q > CNT_W'(STACK_DEPTH))
  // A push never lands on a full stack.
  `ITP_NEVER(a_push_full, mem_we && full)
  // A result is never loaded over one that is still waiting.
  `ITP_NEVER(a_out_overrun, out_load && !out_free)
  // Flags only travel on the last beat of a run.
  `ITP_ASSERT(a_flags_last, (out_valid_o && !out_data_o.last) |-> (!out_data_o.overflow && !out_data_o.aborted))
  // No token is held back while a new input beat may be taken.
  `ITP_ASSERT(a_idle_no_pend, in_ready_o |-> !pend_valid_q)

endmodule

FILE: bench/infix_to_postfix_reorder_core_tb.sv
// Self-checking testbench for the infix to postfix token reorder core.
`timescale 1ns / 100ps

module infix_to_postfix_reorder_core_tb;
  import itp_pkg::*;

  // Kinds 6 and 7 both abort the expression; the package names only the legal ones.
  localparam logic [2:0] KIND_ABORT = 3'd6;
  localparam logic [2:0] KIND_SPARE = 3'd7;
  localparam logic       REQ_TOKEN  = 1'b0;
  localparam logic       REQ_END    = 1'b1;

  // The slowest beat pops a full stack, and this tail leaves ample room
  // for any stray result beat to show up after the last one.
  localparam int TAIL_CYCLES = 120;
  localparam int HOLD_OFF_CYCLES = 600;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  infix_to_postfix_reorder_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Stimulus and checking state. Idle percentages and the hold-off flag only
  // change on the falling edge, so the clocked processes never race them.
  in_beat_t     pending_items[$];
  out_beat_t    postfix_expect[$];
  out_beat_t    released[$];
  stack_entry_t op_stack [STACK_DEPTH];
  int           op_depth = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_off = 1'b0;
  int           taken_count = 0;
  int           mismatches = 0;

  function automatic in_beat_t make_beat(logic req, logic [2:0] kind,
                                         logic [TOKEN_ID_WIDTH-1:0] id,
                                         logic [2:0] prec, logic assoc);
    in_beat_t b;
    b.req_type   = req;
    b.token_kind = kind;
    b.token_id   = id;
    b.precedence = prec;
    b.left_assoc = assoc;
    return b;
  endfunction

  function automatic in_beat_t rand_token(logic [2:0] kind);
    return make_beat(REQ_TOKEN, kind, TOKEN_ID_WIDTH'($urandom()), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
  endfunction

  // An end beat carries random junk in the fields that it ignores.
  function automatic in_beat_t rand_end();
    return make_beat(REQ_END, 3'($urandom_range(0, 7)), TOKEN_ID_WIDTH'($urandom()),
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic in_beat_t rand_noise();
    return make_beat($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)),
                     TOKEN_ID_WIDTH'($urandom()), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
  endfunction

  function automatic string beat_text(out_beat_t b);
    return $sformatf("has=%0d id=%h kind=%0d last=%0d ovf=%0d abt=%0d", b.has_token,
                     b.token_id_out, b.token_kind_out, b.last, b.overflow, b.aborted);
  endfunction

  // Pops the top entry of the operator stack into the current run of results.
  function automatic void pop_to_output();
    out_beat_t r;
    op_depth = op_depth - 1;
    r = '0;
    r.has_token      = 1'b1;
    r.token_id_out   = op_stack[op_depth].id;
    r.token_kind_out = op_stack[op_depth].kind;
    released.push_back(r);
  endfunction

  // Returns 0 when the stack is full and the entry is dropped.
  function automatic bit push_operator(in_beat_t b);
    if (op_depth >= STACK_DEPTH) return 1'b0;
    op_stack[op_depth].id    = b.token_id;
    op_stack[op_depth].kind  = b.token_kind;
    op_stack[op_depth].prec  = b.precedence;
    op_stack[op_depth].assoc = b.left_assoc;
    op_depth = op_depth + 1;
    return 1'b1;
  endfunction

  // An incoming operator releases every stacked function and every operator
  // that binds tighter, or equally tight when the stacked one is left
  // associative. A left parenthesis always stops it.
  function automatic bit yields_to(stack_entry_t top, logic [2:0] prec);
    if (top.kind == KIND_LPAREN) return 1'b0;
    return top.kind == KIND_FUNC || top.prec > prec || (top.prec == prec && top.assoc);
  endfunction

  // Works out the result beats that one accepted input beat releases and
  // queues them behind whatever is still outstanding.
  function automatic void predict_postfix(in_beat_t b);
    out_beat_t r;
    logic      ovf;
    logic      abt;
    ovf = 1'b0;
    abt = 1'b0;
    released.delete();
    if (b.req_type == REQ_END) begin
      while (op_depth > 0) pop_to_output();
    end else begin
      case (b.token_kind)
        KIND_CONST, KIND_NAMED: begin
          r = '0;
          r.has_token      = 1'b1;
          r.token_id_out   = b.token_id;
          r.token_kind_out = b.token_kind;
          released.push_back(r);
        end
        KIND_FUNC, KIND_LPAREN: begin
          ovf = !push_operator(b);
        end
        KIND_OPER: begin
          while (op_depth > 0 && yields_to(op_stack[op_depth-1], b.precedence)) pop_to_output();
          ovf = !push_operator(b);
        end
        KIND_RPAREN: begin
          // The matching left parenthesis is dropped; a function under it stays.
          while (op_depth > 0 && op_stack[op_depth-1].kind != KIND_LPAREN) pop_to_output();
          if (op_depth > 0) op_depth = op_depth - 1;
        end
        default: begin
          op_depth = 0;
          abt = 1'b1;
        end
      endcase
    end
    // A beat that releases nothing still answers with one empty result.
    if (released.size() == 0) released.push_back('0);
    r = released[released.size()-1];
    r.last     = 1'b1;
    r.overflow = ovf;
    r.aborted  = abt;
    released[released.size()-1] = r;
    foreach (released[i]) postfix_expect.push_back(released[i]);
  endfunction

  // Builds a random well-formed infix expression from a small grammar:
  // operands are constants, named tokens, parenthesized groups or function
  // calls, joined by operators. Now and then the sequence is broken on purpose.
  task automatic gen_expression();
    in_beat_t expr[$];
    int       depth;
    int       goal;
    int       pick;
    int       pos;
    bit       want_operand;
    bit       finished;
    depth = 0;
    goal = $urandom_range(3, 24);
    want_operand = 1'b1;
    finished = 1'b0;
    while (!finished) begin
      pick = $urandom_range(0, 99);
      if (want_operand) begin
        if (depth < 6 && expr.size() < goal && pick < 20) begin
          expr.push_back(rand_token(KIND_LPAREN));
          depth++;
        end else if (depth < 6 && expr.size() < goal && pick < 35) begin
          expr.push_back(rand_token(KIND_FUNC));
          expr.push_back(rand_token(KIND_LPAREN));
          depth++;
        end else begin
          expr.push_back(rand_token($urandom_range(0, 1) ? KIND_CONST : KIND_NAMED));
          want_operand = 1'b0;
        end
      end else if (depth > 0 && (pick < 30 || expr.size() >= goal)) begin
        expr.push_back(rand_token(KIND_RPAREN));
        depth--;
      end else if (expr.size() < goal) begin
        expr.push_back(rand_token(KIND_OPER));
        want_operand = 1'b1;
      end else begin
        finished = 1'b1;
      end
    end
    // Broken sequences: a lost token, a stray one, or an abort in the middle.
    if ($urandom_range(0, 99) < 20) begin
      pos = $urandom_range(0, expr.size() - 1);
      case ($urandom_range(0, 2))
        0: expr.delete(pos);
        1: expr.insert(pos, rand_noise());
        default: expr.insert(pos, rand_token($urandom_range(0, 1) ? KIND_ABORT : KIND_SPARE));
      endcase
    end
    // Sometimes the end beat is missing and the next expression inherits the stack.
    if ($urandom_range(0, 99) < 92) expr.push_back(rand_end());
    foreach (expr[i]) pending_items.push_back(expr[i]);
  endtask

  // Nests past the stack depth so pushes get dropped, then flushes a full stack.
  task automatic gen_overflow_run();
    repeat (STACK_DEPTH + 2)
      pending_items.push_back(rand_token($urandom_range(0, 1) ? KIND_FUNC : KIND_LPAREN));
    pending_items.push_back(rand_token(KIND_OPER));
    pending_items.push_back(rand_end());
  endtask

  task automatic fill_phase(int goal);
    while (pending_items.size() < goal) begin
      if ($urandom_range(0, 99) < 80) begin
        gen_expression();
      end else begin
        repeat ($urandom_range(1, 3)) pending_items.push_back(rand_noise());
      end
    end
  endtask

  // Waits until every queued beat has been taken, then steps to a falling edge.
  task automatic drain_inputs();
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    @(negedge clk);
  endtask

  // Driver: offers the next pending beat unless it decides to idle. A beat
  // on the bus stays there unchanged until the block takes it.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_postfix(in_data);
        taken_count <= taken_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result beat against the oldest expectation
  // and draws a fresh ready for the next cycle.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (postfix_expect.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with nothing expected, expected none, actual %s",
                   $time, beat_text(out_data));
        end else begin
          if (out_data.has_token      !== postfix_expect[0].has_token      ||
              out_data.token_id_out   !== postfix_expect[0].token_id_out   ||
              out_data.token_kind_out !== postfix_expect[0].token_kind_out ||
              out_data.last           !== postfix_expect[0].last           ||
              out_data.overflow       !== postfix_expect[0].overflow       ||
              out_data.aborted        !== postfix_expect[0].aborted) begin
            mismatches++;
            $display("%0t ns: result mismatch, expected %s, actual %s", $time,
                     beat_text(postfix_expect[0]), beat_text(out_data));
          end
          void'(postfix_expect.pop_front());
        end
      end
      out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Back pressure: once traffic is flowing, the receiver holds off for a long
  // stretch while the sender keeps offering, so the block backs up and stalls
  // its input.
  initial begin
    wait (rst_n && taken_count >= 40);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(10_000_000);
    $display("infix_to_postfix_reorder_core_tb failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening, no idling on either side.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_CONST, 16'h0000, 3'd0, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_NAMED, 16'hFFFF, 3'd7, 1'b1));
    // End on an empty stack gives a single empty result; its other fields are junk.
    pending_items.push_back(make_beat(REQ_END, KIND_SPARE, 16'hA5A5, 3'd7, 1'b1));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_FUNC, 16'h0101, 3'd7, 1'b1));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_LPAREN, 16'h0202, 3'd0, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_CONST, 16'h0303, 3'd5, 1'b1));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_OPER, 16'h0404, 3'd0, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_CONST, 16'h0505, 3'd0, 1'b0));
    // Equal precedence over a right associative entry: nothing pops.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_OPER, 16'h0606, 3'd0, 1'b1));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_CONST, 16'h0707, 3'd0, 1'b0));
    // Equal precedence over a left associative entry: that one pops.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_OPER, 16'h0808, 3'd0, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_CONST, 16'h0909, 3'd0, 1'b0));
    // Tighter binding operator goes on top without popping.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_OPER, 16'h0A0A, 3'd7, 1'b1));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_CONST, 16'h0B0B, 3'd0, 1'b0));
    // Looser binding operator pops the tighter one and stops at the lower entry.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_OPER, 16'h1616, 3'd1, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_CONST, 16'h1717, 3'd0, 1'b0));
    // Right parenthesis empties its group; the function under it stays stacked.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_RPAREN, 16'h0C0C, 3'd0, 1'b0));
    // The next operator releases the function.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_OPER, 16'h0D0D, 3'd3, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_CONST, 16'h0E0E, 3'd0, 1'b0));
    pending_items.push_back(make_beat(REQ_END, KIND_CONST, 16'h0000, 3'd0, 1'b0));
    // Unmatched right parenthesis, first on an empty stack, then over an operator.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_RPAREN, 16'h0F0F, 3'd0, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_OPER, 16'h1010, 3'd5, 1'b1));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_RPAREN, 16'h1111, 3'd0, 1'b0));
    // Unknown kinds throw the stack away, whether it holds entries or not.
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_LPAREN, 16'h1212, 3'd0, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_OPER, 16'h1313, 3'd2, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_ABORT, 16'h1414, 3'd0, 1'b0));
    pending_items.push_back(make_beat(REQ_TOKEN, KIND_SPARE, 16'h1515, 3'd0, 1'b0));
    gen_overflow_run();
    fill_phase(120);
    drain_inputs();

    // Sender mostly idle.
    send_idle_pct = 75;
    recv_stall_pct = 0;
    fill_phase(110);
    drain_inputs();

    // Receiver mostly stalled.
    send_idle_pct = 0;
    recv_stall_pct = 75;
    fill_phase(110);
    drain_inputs();

    // Light idling on both sides, with a second overflow run.
    send_idle_pct = 13;
    recv_stall_pct = 13;
    gen_overflow_run();
    fill_phase(110);
    drain_inputs();

    while (postfix_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && postfix_expect.size() == 0) begin
      $display("infix_to_postfix_reorder_core_tb passed");
    end else begin
      $display("infix_to_postfix_reorder_core_tb failed");
    end
    $finish;
  end

endmodule
